FILE: rtl/fpe_pkg.sv
package fpe_pkg;

    localparam int PANEL_WIDTH  = 32;
    localparam int PANEL_HEIGHT = 8;

    localparam int COORD_W    = 11;
    localparam int WORD_W     = 32;
    localparam int BIT_IDX_W  = 5;
    localparam int DIRTY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_FETCH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ROP_COPY = 2'd0,
        ROP_OR   = 2'd1,
        ROP_AND  = 2'd2,
        ROP_XOR  = 2'd3
    } t_rop;

    typedef enum logic [1:0] {
        VP_NONE    = 2'd0,
        VP_INSIDE  = 2'd1,
        VP_OUTSIDE = 2'd2,
        VP_NONE_2  = 2'd3
    } t_vp_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VP_LEFT   = 3'd0,
        CFG_VP_TOP    = 3'd1,
        CFG_VP_RIGHT  = 3'd2,
        CFG_VP_BOTTOM = 3'd3,
        CFG_VP_KIND   = 3'd4
    } t_cfg_idx;

endpackage

FILE: rtl/fpe_if.sv
interface fpe_item_if import fpe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] column;
    logic signed [COORD_W-1:0] row;
    logic                      color;
    logic [1:0]                raster_op;

    modport source (output valid, mode, column, row, color, raster_op, input ready);
    modport sink   (input valid, mode, column, row, color, raster_op, output ready);
endinterface

interface fpe_result_if import fpe_pkg::*;;
    logic               valid;
    logic               ready;
    logic               pixel_value;
    logic [DIRTY_W-1:0] dirty_panels;

    modport source (output valid, pixel_value, dirty_panels, input ready);
    modport sink   (input valid, pixel_value, dirty_panels, output ready);
endinterface

interface fpe_cfg_if import fpe_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/framebuffer_pixel_engine_unit.sv
// One-bit framebuffer for a grid of 32x8 LED panels, kept in a single-port-write,
// registered-read word memory of 8 words per panel. For a pixel write, pixel read or
// dirty-mask fetch the word is read in the cycle the item is accepted; in the next, a
// write puts back the word with its bit modified if that bit changes, and the result
// register is loaded. A clear walks every word, one per cycle, before its result
// appears; after reset the same sweep zeroes the store and no item is accepted until
// it is done. Configuration writes are taken at any time.
module framebuffer_pixel_engine_unit
    import fpe_pkg::*;
#(
    parameter int PANELS_ACROSS = 4,
    parameter int PANELS_DOWN   = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpe_cfg_if.sink       i_cfg,
    fpe_item_if.sink      i_item,
    fpe_result_if.source  o_result
);

    localparam int SCREEN_W    = PANELS_ACROSS * PANEL_WIDTH;
    localparam int SCREEN_H    = PANELS_DOWN * PANEL_HEIGHT;
    localparam int NUM_PANELS  = PANELS_ACROSS * PANELS_DOWN;
    localparam int STORE_WORDS = NUM_PANELS * PANEL_HEIGHT;
    localparam int PANEL_BITS  = (NUM_PANELS > 1) ? $clog2(NUM_PANELS) : 1;
    localparam int AW          = PANEL_BITS + 3;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RMW   = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_vp_left, r_vp_top, r_vp_right, r_vp_bottom;
    logic [1:0]                r_vp_kind;

    logic [WORD_W-1:0] mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rdata;

    logic [AW-1:0]         r_addr, n_addr;
    logic [BIT_IDX_W-1:0]  r_bit, n_bit;
    logic [PANEL_BITS-1:0] r_panel, n_panel;
    logic [1:0]            r_mode, n_mode;
    logic [1:0]            r_op, n_op;
    logic                  r_color, n_color;
    logic                  r_wr, n_wr;
    logic                  r_rd, n_rd;
    logic [AW-1:0]         r_clr_cnt, n_clr_cnt;
    logic                  r_clr_item, n_clr_item;
    logic [NUM_PANELS-1:0] r_dirty, n_dirty;

    logic               r_out_valid, n_out_valid;
    logic               r_out_pix, n_out_pix;
    logic [DIRTY_W-1:0] r_out_dirty, n_out_dirty;

    logic                  in_acc;
    logic                  on_screen, in_vp, blocked;
    logic [5:0]            panel_full;
    logic [AW-1:0]         in_addr;
    logic                  prev, newc, changed;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [63:0]           dirty_ext;

    assign i_cfg.ready       = 1'b1;
    assign i_item.ready      = (r_state == S_IDLE) && (!r_out_valid || o_result.ready);
    assign in_acc            = i_item.valid && i_item.ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.pixel_value  = r_out_pix;
    assign o_result.dirty_panels = r_out_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_left   <= '0;
            r_vp_top    <= '0;
            r_vp_right  <= '0;
            r_vp_bottom <= '0;
            r_vp_kind   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_VP_LEFT:   r_vp_left   <= i_cfg.data;
                CFG_VP_TOP:    r_vp_top    <= i_cfg.data;
                CFG_VP_RIGHT:  r_vp_right  <= i_cfg.data;
                CFG_VP_BOTTOM: r_vp_bottom <= i_cfg.data;
                CFG_VP_KIND:   r_vp_kind   <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        on_screen = !i_item.column[COORD_W-1]
                 && (i_item.column[COORD_W-2:0] < (COORD_W-1)'(SCREEN_W))
                 && !i_item.row[COORD_W-1]
                 && (i_item.row[COORD_W-2:0] < (COORD_W-1)'(SCREEN_H));
        in_vp   = (i_item.column >= r_vp_left) && (i_item.column <= r_vp_right)
               && (i_item.row >= r_vp_top) && (i_item.row <= r_vp_bottom);
        blocked = ((r_vp_kind == VP_INSIDE) && !in_vp)
               || ((r_vp_kind == VP_OUTSIDE) && in_vp);
        panel_full = 6'(i_item.row[5:3]) * 6'(PANELS_ACROSS) + 6'(i_item.column[7:5]);
        in_addr    = {panel_full[PANEL_BITS-1:0], ~i_item.column[4:2]};
    end

    // Read-modify-write of the addressed bit
    always_comb begin
        prev = r_rdata[r_bit];
        case (r_op)
            ROP_OR:  newc = prev | r_color;
            ROP_AND: newc = prev & r_color;
            ROP_XOR: newc = prev ^ r_color;
            default: newc = r_color;
        endcase
        changed   = r_wr && (newc != prev);
        mem_we    = ((r_state == S_RMW) && changed) || (r_state == S_CLEAR);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_addr;
        mem_wdata = (r_state == S_CLEAR) ? {WORD_W{r_color}}
                                         : (r_rdata ^ (WORD_W'(1) << r_bit));
        dirty_ext = 64'(r_dirty);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[in_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_panel     = r_panel;
        n_mode      = r_mode;
        n_op        = r_op;
        n_color     = r_color;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_clr_cnt   = r_clr_cnt;
        n_clr_item  = r_clr_item;
        n_dirty     = r_dirty;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_pix   = r_out_pix;
        n_out_dirty = r_out_dirty;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr  = in_addr;
                    n_bit   = {~i_item.column[1:0], ~i_item.row[2:0]};
                    n_panel = panel_full[PANEL_BITS-1:0];
                    n_mode  = i_item.mode;
                    n_op    = i_item.raster_op;
                    n_color = i_item.color;
                    n_wr    = (i_item.mode == MODE_WRITE) && on_screen && !blocked;
                    n_rd    = (i_item.mode == MODE_READ) && on_screen;
                    if (i_item.mode == MODE_CLEAR) begin
                        n_state    = S_CLEAR;
                        n_clr_cnt  = '0;
                        n_clr_item = 1'b1;
                    end else begin
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                n_out_valid = 1'b1;
                n_out_pix   = r_rd & prev;
                n_out_dirty = '0;
                if (r_mode == MODE_FETCH) begin
                    n_out_dirty = dirty_ext[DIRTY_W-1:0];
                    n_dirty     = '0;
                end else if (changed) begin
                    n_dirty = r_dirty | (NUM_PANELS'(1) << r_panel);
                end
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_item) begin
                        n_dirty     = '1;
                        n_out_valid = 1'b1;
                        n_out_pix   = 1'b0;
                        n_out_dirty = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_item  <= 1'b0;
            r_color     <= 1'b0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
            r_rd        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_item  <= n_clr_item;
            r_color     <= n_color;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_bit       <= n_bit;
        r_panel     <= n_panel;
        r_mode      <= n_mode;
        r_op        <= n_op;
        r_out_pix   <= n_out_pix;
        r_out_dirty <= n_out_dirty;
    end

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RMW) || (r_state == S_CLEAR))
        else $error("accepted transaction did not start work");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> !r_out_valid)
        else $error("result register busy when result is produced");

    a_clear_marks_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && r_clr_item && (r_clr_cnt == AW'(STORE_WORDS - 1)))
        |=> (&r_dirty) && r_out_valid)
        else $error("clear did not mark all panels dirty");

endmodule

FILE: dv/framebuffer_pixel_engine_unit_tb.sv
`timescale 1ns / 100ps

module framebuffer_pixel_engine_unit_tb;
    import fpe_pkg::*;

    localparam int PANELS_ACROSS = 4;
    localparam int PANELS_DOWN   = 4;
    localparam int SCREEN_COLS   = PANELS_ACROSS * PANEL_WIDTH;
    localparam int SCREEN_ROWS   = PANELS_DOWN * PANEL_HEIGHT;
    localparam int PHASE_ITEMS   = 220;
    localparam int NUM_PHASES    = 8;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        logic               pixel;
        logic [DIRTY_W-1:0] panels;
    } t_outcome;

    class framebuffer_shadow;
        bit                 screen [SCREEN_ROWS][SCREEN_COLS];
        bit [DIRTY_W-1:0]   dirty;
        int                 vp_left, vp_top, vp_right, vp_bottom;
        t_vp_kind           vp_kind;
        t_outcome           pending_outcomes[$];
        int                 errors;

        function new();
            foreach (screen[r, c]) screen[r][c] = 1'b0;
            dirty     = '0;
            vp_left   = 0;
            vp_top    = 0;
            vp_right  = 0;
            vp_bottom = 0;
            vp_kind   = VP_NONE;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VP_LEFT:   vp_left   = int'(signed'(data));
                CFG_VP_TOP:    vp_top    = int'(signed'(data));
                CFG_VP_RIGHT:  vp_right  = int'(signed'(data));
                CFG_VP_BOTTOM: vp_bottom = int'(signed'(data));
                CFG_VP_KIND:   vp_kind   = t_vp_kind'(data[1:0]);
                default: ;
            endcase
        endfunction

        // update the shadow image and queue the outcome of one transaction
        function void note_item(t_mode mode, t_coord col, t_coord row, logic color, t_rop rop);
            t_outcome o;
            int       x, y;
            bit       on, in_vp, blocked, prev, nxt;
            x = int'(col);
            y = int'(row);
            o.pixel  = 1'b0;
            o.panels = '0;
            on = x >= 0 && x < SCREEN_COLS && y >= 0 && y < SCREEN_ROWS;
            case (mode)
                MODE_WRITE: begin
                    if (on) begin
                        in_vp   = x >= vp_left && x <= vp_right && y >= vp_top && y <= vp_bottom;
                        blocked = (vp_kind == VP_INSIDE && !in_vp) ||
                                  (vp_kind == VP_OUTSIDE && in_vp);
                        if (!blocked) begin
                            prev = screen[y][x];
                            case (rop)
                                ROP_OR:  nxt = prev | color;
                                ROP_AND: nxt = prev & color;
                                ROP_XOR: nxt = prev ^ color;
                                default: nxt = color;
                            endcase
                            if (nxt != prev) begin
                                screen[y][x] = nxt;
                                dirty[(y / PANEL_HEIGHT) * PANELS_ACROSS + x / PANEL_WIDTH] = 1'b1;
                            end
                        end
                    end
                end
                MODE_READ: begin
                    if (on) o.pixel = screen[y][x];
                end
                MODE_CLEAR: begin
                    foreach (screen[r, c]) screen[r][c] = color;
                    dirty = '1;
                end
                default: begin
                    o.panels = dirty;
                    dirty    = '0;
                end
            endcase
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(logic pixel, logic [DIRTY_W-1:0] panels);
            t_outcome o;
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result transaction: pixel_value %0d dirty_panels 0x%04h",
                       pixel, panels);
                errors++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (pixel !== o.pixel) begin
                $error("pixel_value: expected %0d, actual %0d", o.pixel, pixel);
                errors++;
            end
            if (panels !== o.panels) begin
                $error("dirty_panels: expected 0x%04h, actual 0x%04h", o.panels, panels);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fpe_cfg_if    cfg_bus ();
    fpe_item_if   item_bus ();
    fpe_result_if result_bus ();

    framebuffer_pixel_engine_unit #(
        .PANELS_ACROSS(PANELS_ACROSS),
        .PANELS_DOWN  (PANELS_DOWN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_item  (item_bus),
        .o_result(result_bus)
    );

    framebuffer_shadow shadow = new();
    bit tx_eager;
    bit rx_eager;
    int hot_x;
    int hot_y;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("framebuffer_pixel_engine_unit: mismatch");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the pipeline
    initial begin
        int stall_left;
        int results_taken;
        result_bus.ready <= 1'b0;
        stall_left    = 0;
        results_taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                shadow.check_result(result_bus.pixel_value, result_bus.dirty_panels);
                results_taken++;
                stall_left = rx_eager ? 0 : $urandom_range(0, 9);
                if (results_taken == 500) stall_left = 300;
            end
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(t_mode mode, t_coord col, t_coord row, logic color, t_rop rop);
        int gap;
        if (item_bus.valid !== 1'b1) item_bus.valid <= 1'b1;
        item_bus.mode      <= mode;
        item_bus.column    <= col;
        item_bus.row       <= row;
        item_bus.color     <= color;
        item_bus.raster_op <= rop;
        @(posedge i_clk);
        while (item_bus.ready !== 1'b1) @(posedge i_clk);
        shadow.note_item(mode, col, row, color, rop);
        gap = tx_eager ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (item_bus.valid === 1'b1) item_bus.valid <= 1'b0;
        while (shadow.pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_viewport(int left, int top, int right, int bottom, t_vp_kind kind);
        t_cfg_idx              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_VP_LEFT, CFG_VP_TOP, CFG_VP_RIGHT, CFG_VP_BOTTOM, CFG_VP_KIND};
        vals[0] = left[CFG_DATA_W-1:0];
        vals[1] = top[CFG_DATA_W-1:0];
        vals[2] = right[CFG_DATA_W-1:0];
        vals[3] = bottom[CFG_DATA_W-1:0];
        vals[4] = {{(CFG_DATA_W-2){1'b0}}, kind};
        for (int k = 0; k < 5; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= regs[k];
            cfg_bus.data  <= vals[k];
            @(posedge i_clk);
            while (cfg_bus.ready !== 1'b1) @(posedge i_clk);
            shadow.set_reg(regs[k], vals[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_coord rand_coord(int lim, int hot);
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 5) v = hot + int'($urandom_range(0, 7));
        else if (pick < 7) v = int'($urandom_range(0, lim - 1));
        else if (pick < 9) v = int'($urandom_range(0, lim + 3)) - 2;
        else v = int'($urandom_range(0, 2047)) - 1024;
        return v[COORD_W-1:0];
    endfunction

    function automatic int rand_edge();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic random_items(int count);
        int    pick;
        t_mode mode;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) mode = MODE_WRITE;
            else if (pick < 85) mode = MODE_READ;
            else if (pick < 97) mode = MODE_FETCH;
            else mode = MODE_CLEAR;
            send_item(mode, rand_coord(SCREEN_COLS, hot_x), rand_coord(SCREEN_ROWS, hot_y),
                      1'($urandom_range(0, 1)), t_rop'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        int l, t, r, b;
        i_rst_n            <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_VP_LEFT;
        cfg_bus.data       <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.mode      <= MODE_WRITE;
        item_bus.column    <= '0;
        item_bus.row       <= '0;
        item_bus.color     <= 1'b0;
        item_bus.raster_op <= ROP_COPY;
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_viewport(0, 0, 0, 0, VP_NONE);

        // directed: screen corners, off-screen coordinates, every raster op, clear, fetch
        send_item(MODE_WRITE, 0, 0, 1'b1, ROP_COPY);
        send_item(MODE_WRITE, 127, 31, 1'b1, ROP_COPY);
        send_item(MODE_WRITE, -1, 0, 1'b1, ROP_COPY);
        send_item(MODE_WRITE, 128, 31, 1'b1, ROP_COPY);
        send_item(MODE_WRITE, -1024, 1023, 1'b1, ROP_COPY);
        send_item(MODE_READ, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_READ, 127, 31, 1'b0, ROP_COPY);
        send_item(MODE_READ, -1, 0, 1'b0, ROP_COPY);
        send_item(MODE_READ, 1023, -1024, 1'b1, ROP_XOR);
        send_item(MODE_FETCH, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_FETCH, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_WRITE, 5, 3, 1'b1, ROP_OR);
        send_item(MODE_WRITE, 5, 3, 1'b0, ROP_OR);
        send_item(MODE_WRITE, 5, 3, 1'b0, ROP_AND);
        send_item(MODE_WRITE, 5, 3, 1'b1, ROP_XOR);
        send_item(MODE_WRITE, 5, 3, 1'b1, ROP_XOR);
        send_item(MODE_WRITE, 5, 3, 1'b1, ROP_AND);
        send_item(MODE_READ, 5, 3, 1'b0, ROP_COPY);
        send_item(MODE_FETCH, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_CLEAR, 0, 0, 1'b1, ROP_COPY);
        send_item(MODE_READ, 64, 16, 1'b0, ROP_COPY);
        send_item(MODE_WRITE, 64, 16, 1'b0, ROP_COPY);
        send_item(MODE_FETCH, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_CLEAR, 0, 0, 1'b0, ROP_COPY);
        send_item(MODE_READ, 64, 16, 1'b0, ROP_COPY);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            l = $urandom_range(0, 60);
            t = $urandom_range(0, 15);
            r = l + $urandom_range(0, 67);
            b = t + $urandom_range(0, 16);
            case (p)
                0: load_viewport(0, 0, 0, 0, VP_NONE);
                1: load_viewport(l, t, r, b, VP_INSIDE);
                2: load_viewport(l, t, r, b, VP_OUTSIDE);
                3: load_viewport(r, b, l, t, VP_INSIDE);
                4: load_viewport(r, b, l, t, VP_OUTSIDE);
                5: load_viewport(-1024, -1024, 1023, 1023, VP_NONE_2);
                6: load_viewport(1023, 1023, -1024, -1024, VP_INSIDE);
                default: load_viewport(rand_edge(), rand_edge(), rand_edge(), rand_edge(),
                                       VP_OUTSIDE);
            endcase
            // hot window, in phases 1 to 4 often at the viewport corner, so reads find written pixels
            hot_x = (p >= 1 && p <= 4 && $urandom_range(0, 1)) ? l : $urandom_range(0, 120);
            hot_y = (p >= 1 && p <= 4 && $urandom_range(0, 1)) ? t : $urandom_range(0, 24);
            tx_eager = (p % 3 == 0);
            rx_eager = (p % 4 == 2);
            random_items(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending_outcomes.size() == 0) begin
            $display("framebuffer_pixel_engine_unit: match");
        end else begin
            $display("framebuffer_pixel_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
